[hw/rtl/rtfp_pkg.sv]
// Shared constants, types and decode helpers of the radar target frame parser.
`default_nettype none
package rtfp_pkg;

	localparam int TARGET_SLOTS = 3;
	localparam int WIN_LEN      = 30;
	localparam int SLOT_BASE    = 4;
	localparam int SLOT_BYTES   = 8;

	localparam logic [7:0] HDR_B0  = 8'hAA;
	localparam logic [7:0] HDR_B1  = 8'hFF;
	localparam logic [7:0] HDR_B2  = 8'h03;
	localparam logic [7:0] HDR_B3  = 8'h00;
	localparam logic [7:0] TAIL_B0 = 8'h55;
	localparam logic [7:0] TAIL_B1 = 8'hCC;
	localparam logic [7:0] MAG_HI_MASK = 8'h7F;
	localparam logic [7:0] SIGN_MASK   = 8'h80;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SLOT,
		ST_SQX,
		ST_SQY,
		ST_RSTART,
		ST_ROOT,
		ST_EMIT,
		ST_EMPTY
	} rtfp_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rtfp_root_stat_t;

	// Magnitude of a sign-magnitude word, low byte first.
	function automatic logic [14:0] sm_mag(input logic [7:0] lo, input logic [7:0] hi);
		logic [7:0] h;
		h = hi & MAG_HI_MASK;
		return {h[6:0], lo};
	endfunction

	// Sign bit set means positive; a zero magnitude gives zero either way.
	function automatic logic signed [15:0] sm_value(input logic [7:0] lo, input logic [7:0] hi);
		logic [15:0] m;
		m = {1'b0, sm_mag(lo, hi)};
		return ((hi & SIGN_MASK) != 8'h00) ? $signed(m) : -$signed(m);
	endfunction

endpackage
`default_nettype wire

[hw/rtl/rtfp_if.sv]
// Valid/ready channel interfaces for the received bytes and the target results.
`default_nettype none
interface rtfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rtfp_out_if;
	logic               valid;
	logic               ready;
	logic               target_valid;
	logic signed [15:0] x_mm;
	logic signed [15:0] y_mm;
	logic signed [15:0] vel_cms;
	logic [15:0]        resolution_mm;
	logic [15:0]        distance_mm;
	logic [15:0]        nearest_mm;
	logic [1:0]         target_total;
	logic               last_of_frame;

	modport source (output valid, output target_valid, output x_mm, output y_mm,
		output vel_cms, output resolution_mm, output distance_mm, output nearest_mm,
		output target_total, output last_of_frame, input ready);
	modport sink (input valid, input target_valid, input x_mm, input y_mm,
		input vel_cms, input resolution_mm, input distance_mm, input nearest_mm,
		input target_total, input last_of_frame, output ready);
endinterface
`default_nettype wire

[hw/rtl/rtfp_isqrt.sv]
// Iterative integer square root, one remainder/compare step per cycle.
`default_nettype none
module rtfp_isqrt
	import rtfp_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [31:0]     value,
	output      logic [15:0]     root,
	output      rtfp_root_stat_t stat
);

	logic [31:0] rem_q, res_q, bit_q;
	logic        busy_q, done_q;
	logic [31:0] trial;
	logic        fits;

	assign trial = res_q + bit_q;
	assign fits  = rem_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= value;
			res_q <= '0;
			bit_q <= 32'h4000_0000;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root      = res_q[15:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
`default_nettype wire

[hw/rtl/radar_target_frame_parser_core.sv]
// Top level of the radar target frame parser: byte window, frame check and target sequencer.
`default_nettype none
// Bytes enter on rx and shift into a 30-byte window; until the window first fills, one byte
// is taken every cycle. Every byte that completes a full window is followed by the header
// (AA FF 03 00) and tail (55 CC) check in ST_CHECK; on a mismatch the oldest byte drops out
// and the search goes on, so while the search slides each byte is checked before the next is taken.
// A matching frame is decoded slot by slot while rx is held off: an empty slot is skipped,
// a target passes through two squarings on the shared multiplier, then the 16-step square
// root unit, then the hand-off to the output register. Each result sits in an output
// register until tgt accepts it; a frame with no target gives one result with
// target_valid low and last_of_frame high. nearest_mm is the running minimum distance
// within the frame, so the last result carries the frame's nearest target.
module radar_target_frame_parser_core
	import rtfp_pkg::*;
(
	input wire logic   clk,
	input wire logic   arst_n,
	rtfp_in_if.sink    rx,
	rtfp_out_if.source tgt
);

	localparam logic [1:0] SLOTS_C = 2'(TARGET_SLOTS);
	localparam logic [4:0] FULL_C  = 5'(WIN_LEN);
	localparam logic [4:0] KEEP_C  = 5'(WIN_LEN - 1);

	rtfp_state_t state_q, state_d;

	logic [7:0]  win_q [WIN_LEN];
	logic [4:0]  fill_q;
	logic [1:0]  cursor_q, total_q, done_q;
	logic [15:0] nearest_q;
	logic [30:0] acc_q;

	logic [7:0]  sb [SLOT_BYTES];
	logic        in_acc, frame_ok, slot_empty, out_free, root_start;
	logic [1:0]  total_c;
	logic [14:0] ax, ay, mul_op;
	logic [29:0] prod;
	logic [15:0] root, near_new;
	rtfp_root_stat_t root_stat;

	logic               out_valid_q, out_tv_q, out_last_q;
	logic signed [15:0] out_x_q, out_y_q, out_v_q;
	logic [15:0]        out_res_q, out_dist_q, out_near_q;
	logic [1:0]         out_total_q;

	assign in_acc   = rx.valid && rx.ready;
	assign rx.ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || tgt.ready;

	assign frame_ok = win_q[0] == HDR_B0 && win_q[1] == HDR_B1 && win_q[2] == HDR_B2 &&
		win_q[3] == HDR_B3 && win_q[WIN_LEN-2] == TAIL_B0 && win_q[WIN_LEN-1] == TAIL_B1;

	// Count non-empty slots over the whole window.
	always_comb begin
		total_c = '0;
		for (int s = 0; s < TARGET_SLOTS; s++) begin
			if (!(sm_mag(win_q[SLOT_BASE+s*SLOT_BYTES],   win_q[SLOT_BASE+s*SLOT_BYTES+1]) == '0 &&
			      sm_mag(win_q[SLOT_BASE+s*SLOT_BYTES+2], win_q[SLOT_BASE+s*SLOT_BYTES+3]) == '0 &&
			      sm_mag(win_q[SLOT_BASE+s*SLOT_BYTES+4], win_q[SLOT_BASE+s*SLOT_BYTES+5]) == '0))
				total_c = total_c + 2'd1;
		end
	end

	// Bytes of the slot under the cursor.
	always_comb begin
		for (int k = 0; k < SLOT_BYTES; k++) begin
			unique case (cursor_q)
				2'd0:    sb[k] = win_q[SLOT_BASE + k];
				2'd1:    sb[k] = win_q[SLOT_BASE + SLOT_BYTES + k];
				2'd2:    sb[k] = win_q[SLOT_BASE + 2*SLOT_BYTES + k];
				default: sb[k] = '0;
			endcase
		end
	end

	assign ax         = sm_mag(sb[0], sb[1]);
	assign ay         = sm_mag(sb[2], sb[3]);
	assign slot_empty = ax == '0 && ay == '0 && sm_mag(sb[4], sb[5]) == '0;
	assign mul_op     = (state_q == ST_SQX) ? ax : ay;
	assign prod       = {15'd0, mul_op} * {15'd0, mul_op};
	assign near_new   = (done_q == 2'd0 || root < nearest_q) ? root : nearest_q;
	assign root_start = (state_q == ST_RSTART);

	rtfp_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.value  ({1'b0, acc_q}),
		.root   (root),
		.stat   (root_stat)
	);

	// Shift line: the window always holds the latest bytes, the newest at the top.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int i = 0; i < WIN_LEN - 1; i++) win_q[i] <= win_q[i+1];
			win_q[WIN_LEN-1] <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_acc && fill_q == KEEP_C) state_d = ST_CHECK;
			ST_CHECK:  state_d = frame_ok ? ST_SLOT : ST_IDLE;
			ST_SLOT: begin
				if (cursor_q == SLOTS_C)
					state_d = (total_q == 2'd0) ? ST_EMPTY : ST_IDLE;
				else if (!slot_empty)
					state_d = ST_SQX;
			end
			ST_SQX:    state_d = ST_SQY;
			ST_SQY:    state_d = ST_RSTART;
			ST_RSTART: state_d = ST_ROOT;
			ST_ROOT:   if (root_stat.done) state_d = ST_EMIT;
			ST_EMIT:   if (out_free) state_d = ST_SLOT;
			ST_EMPTY:  if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Frame bookkeeping: fill count, slot cursor, target counts and running nearest.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			cursor_q  <= '0;
			total_q   <= '0;
			done_q    <= '0;
			nearest_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (in_acc) fill_q <= fill_q + 5'd1;
				ST_CHECK: begin
					fill_q <= frame_ok ? 5'd0 : KEEP_C;
					if (frame_ok) begin
						total_q   <= total_c;
						cursor_q  <= '0;
						done_q    <= '0;
						nearest_q <= '0;
					end
				end
				ST_SLOT: begin
					if (cursor_q == SLOTS_C) cursor_q <= '0;
					else if (slot_empty)     cursor_q <= cursor_q + 2'd1;
				end
				ST_EMIT: begin
					if (out_free) begin
						cursor_q  <= cursor_q + 2'd1;
						done_q    <= done_q + 2'd1;
						nearest_q <= near_new;
					end
				end
				default: ;
			endcase
		end
	end

	// Shared multiplier: square x, then add the square of y.
	always_ff @(posedge clk) begin
		if (state_q == ST_SQX)      acc_q <= {1'b0, prod};
		else if (state_q == ST_SQY) acc_q <= acc_q + {1'b0, prod};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free && (state_q == ST_EMIT || state_q == ST_EMPTY)) begin
			out_valid_q <= 1'b1;
		end else if (tgt.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && state_q == ST_EMIT) begin
			out_tv_q    <= 1'b1;
			out_x_q     <= sm_value(sb[0], sb[1]);
			out_y_q     <= sm_value(sb[2], sb[3]);
			out_v_q     <= sm_value(sb[4], sb[5]);
			out_res_q   <= {sb[7], sb[6]};
			out_dist_q  <= root;
			out_near_q  <= near_new;
			out_total_q <= total_q;
			out_last_q  <= (done_q + 2'd1) == total_q;
		end else if (out_free && state_q == ST_EMPTY) begin
			out_tv_q    <= 1'b0;
			out_x_q     <= '0;
			out_y_q     <= '0;
			out_v_q     <= '0;
			out_res_q   <= '0;
			out_dist_q  <= '0;
			out_near_q  <= '0;
			out_total_q <= '0;
			out_last_q  <= 1'b1;
		end
	end

	assign tgt.valid         = out_valid_q;
	assign tgt.target_valid  = out_tv_q;
	assign tgt.x_mm          = out_x_q;
	assign tgt.y_mm          = out_y_q;
	assign tgt.vel_cms       = out_v_q;
	assign tgt.resolution_mm = out_res_q;
	assign tgt.distance_mm   = out_dist_q;
	assign tgt.nearest_mm    = out_near_q;
	assign tgt.target_total  = out_total_q;
	assign tgt.last_of_frame = out_last_q;

	a_check_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHECK |-> fill_q == FULL_C)
		else $error("frame check without a full window");

	a_root_idle: assert property (@(posedge clk) disable iff (!arst_n)
		root_start |-> !root_stat.busy)
		else $error("square root started while busy");

	a_root_done: assert property (@(posedge clk) disable iff (!arst_n)
		root_stat.done |-> state_q == ST_ROOT)
		else $error("square root finished outside its wait state");

	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		tgt.valid && tgt.target_valid |-> tgt.target_total != 2'd0)
		else $error("target result in a frame counted as empty");

endmodule
`default_nettype wire
